@@ rtl/soft_timer_bank_defines.svh @@
// Assertion macros shared by the soft timer bank RTL.
`ifndef SOFT_TIMER_BANK_DEFINES_SVH
`define SOFT_TIMER_BANK_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define STB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("soft_timer_bank: implication check failed");

// Next-cycle implication, checked out of reset
`define STB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("soft_timer_bank: next-cycle check failed");

`else

`define STB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define STB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/stb_pkg.sv @@
// Package with sizes, op codes and sequencer states of the soft timer bank.
package stb_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int COUNT_BITS  = 32;
    localparam int ID_BITS     = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    localparam int OP_BITS     = 3;
    localparam int TID_BITS    = 8;
    localparam int PERIOD_BITS = 32;
    localparam int RT_BITS     = 31;

    // Input beat layout
    localparam int OP_LSB      = 0;
    localparam int TID_LSB     = OP_LSB + OP_BITS;
    localparam int PERIOD_LSB  = TID_LSB + TID_BITS;
    localparam int IN_BITS     = PERIOD_LSB + PERIOD_BITS;
    localparam int S_DATA_BITS = ((IN_BITS + 7) / 8) * 8;

    // Output beat layout
    localparam int FIRED_POS   = 0;
    localparam int RUNNING_POS = 1;
    localparam int RT_LSB      = 2;
    localparam int IDERR_POS   = RT_LSB + RT_BITS;
    localparam int OUT_BITS    = IDERR_POS + 1;
    localparam int M_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [RT_BITS-1:0] RUNTIME_WRAP = 31'h7FFF_FFFF;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK        = 3'd0,
        OP_START_ONCE  = 3'd1,
        OP_START_AUTO  = 3'd2,
        OP_STOP        = 3'd3,
        OP_CHECK       = 3'd4,
        OP_RELOAD      = 3'd5,
        OP_READ_RT     = 3'd6,
        OP_NONE        = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_DONE
    } t_state;

endpackage

@@ rtl/soft_timer_bank.sv @@
// Soft timer bank: countdown timers with one shared decrement unit and a run-time counter.
//
// Usage:
//   Commands enter on the slave stream (s_tvalid/s_tready/s_tdata). Each beat carries
//   op, timer_id and period. Every command yields exactly one result beat on the
//   master stream (m_tvalid/m_tready/m_tdata) with fired, running, run_time, id_error.
//   s_tready is high only while the sequencer is idle; one command is in work at a time.
//   A non-tick command passes through ST_EXEC and ST_DONE to the output register, and
//   the block takes the next command only after the sequencer returns to ST_IDLE.
//   A tick walks the timers through the single decrement/compare unit, one timer per
//   cycle, and then moves on to ST_DONE.
//   The result sits in an output register; while the receiver stalls a finished
//   result holds there and the next command is still accepted and worked on, waiting
//   only at its own hand-off until the register frees up.
//   Reset (i_rst_n low, synchronous) clears all counts, preloads, flags and modes,
//   zeroes the run-time counter and empties the output register.
//   A timer_id at or above TIMER_COUNT raises id_error on start, stop and reload;
//   check with such an id reports zeros.
`include "soft_timer_bank_defines.svh"

module soft_timer_bank
    import stb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] op, [10:3] timer_id, [42:11] period, upper bits zero
    input  logic [S_DATA_BITS-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] fired, [1] running, [32:2] run_time, [33] id_error, upper bits zero
    output logic [M_DATA_BITS-1:0] m_tdata
);

    // Timer state
    logic [COUNT_BITS-1:0] r_count   [TIMER_COUNT];
    logic [COUNT_BITS-1:0] r_preload [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] r_flag;
    logic [TIMER_COUNT-1:0] r_mode;
    logic [RT_BITS-1:0]     r_run_time, n_run_time;

    // Sequencer and captured command
    t_state                r_state, n_state;
    t_op                   r_op;
    logic [TID_BITS-1:0]   r_tid;
    logic [COUNT_BITS-1:0] r_period;
    logic [ID_BITS-1:0]    r_idx, n_idx;

    // Pending result fields
    logic r_fired, n_fired;
    logic r_running, n_running;
    logic r_id_error, n_id_error;

    // Output register
    logic                   r_m_valid;
    logic [M_DATA_BITS-1:0] r_m_data;

    // Shared unit
    logic                  id_ok;
    logic [ID_BITS-1:0]    addr;
    logic [COUNT_BITS-1:0] rd_count;
    logic [COUNT_BITS-1:0] rd_preload;
    logic                  rd_flag;
    logic                  rd_mode;
    logic [COUNT_BITS-1:0] dec_count;
    logic                  s_accept;
    logic                  out_load;
    logic                  last_idx;

    // Write controls for the addressed timer
    logic                  wr_count_en;
    logic [COUNT_BITS-1:0] wr_count;
    logic                  wr_preload_en;
    logic                  wr_flag_en;
    logic                  wr_flag;
    logic                  wr_mode_en;
    logic                  wr_mode;

    assign s_tready = (r_state == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    assign id_ok    = (r_tid < TID_BITS'(TIMER_COUNT));
    assign last_idx = (r_idx == ID_BITS'(TIMER_COUNT - 1));
    assign out_load = (r_state == ST_DONE) && (!r_m_valid || m_tready);

    // Select the timer the shared unit works on
    assign addr       = (r_state == ST_TICK) ? r_idx : r_tid[ID_BITS-1:0];
    assign rd_count   = r_count[addr];
    assign rd_preload = r_preload[addr];
    assign rd_flag    = r_flag[addr];
    assign rd_mode    = r_mode[addr];
    assign dec_count  = rd_count - COUNT_BITS'(1);

    // Sequencer: next state, pending result and timer writes
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_run_time    = r_run_time;
        n_fired       = r_fired;
        n_running     = r_running;
        n_id_error    = r_id_error;
        wr_count_en   = 1'b0;
        wr_count      = r_period;
        wr_preload_en = 1'b0;
        wr_flag_en    = 1'b0;
        wr_flag       = 1'b0;
        wr_mode_en    = 1'b0;
        wr_mode       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_fired    = 1'b0;
                n_running  = 1'b0;
                n_id_error = 1'b0;
                n_state    = ST_DONE;
                case (r_op)
                    OP_TICK: begin
                        if (r_run_time + RT_BITS'(1) == RUNTIME_WRAP) begin
                            n_run_time = '0;
                        end else begin
                            n_run_time = r_run_time + RT_BITS'(1);
                        end
                        n_idx   = '0;
                        n_state = ST_TICK;
                    end
                    OP_START_ONCE, OP_START_AUTO: begin
                        if (id_ok) begin
                            wr_count_en   = 1'b1;
                            wr_count      = r_period;
                            wr_preload_en = 1'b1;
                            wr_flag_en    = 1'b1;
                            wr_flag       = 1'b0;
                            wr_mode_en    = 1'b1;
                            wr_mode       = (r_op == OP_START_AUTO);
                        end else begin
                            n_id_error = 1'b1;
                        end
                    end
                    OP_STOP: begin
                        if (id_ok) begin
                            wr_count_en = 1'b1;
                            wr_count    = '0;
                            wr_flag_en  = 1'b1;
                            wr_flag     = 1'b0;
                            wr_mode_en  = 1'b1;
                            wr_mode     = 1'b0;
                        end else begin
                            n_id_error = 1'b1;
                        end
                    end
                    OP_CHECK: begin
                        if (id_ok) begin
                            n_running  = (rd_count != '0);
                            n_fired    = rd_flag;
                            wr_flag_en = 1'b1;
                            wr_flag    = 1'b0;
                        end
                    end
                    OP_RELOAD: begin
                        if (id_ok) begin
                            wr_count_en = 1'b1;
                            wr_count    = rd_preload;
                        end else begin
                            n_id_error = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_TICK: begin
                // Decrement one timer, flag on expiry and reload it if it is in auto mode
                if (rd_count != '0) begin
                    wr_count_en = 1'b1;
                    wr_count    = dec_count;
                    if (dec_count == '0) begin
                        wr_flag_en = 1'b1;
                        wr_flag    = 1'b1;
                        if (rd_mode) begin
                            wr_count = rd_preload;
                        end
                    end
                end
                if (last_idx) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + ID_BITS'(1);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_run_time <= '0;
            r_fired    <= 1'b0;
            r_running  <= 1'b0;
            r_id_error <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_run_time <= n_run_time;
            r_fired    <= n_fired;
            r_running  <= n_running;
            r_id_error <= n_id_error;
        end
    end

    // Capture the accepted command
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op     <= t_op'(s_tdata[OP_LSB +: OP_BITS]);
            r_tid    <= s_tdata[TID_LSB +: TID_BITS];
            r_period <= s_tdata[PERIOD_LSB +: COUNT_BITS];
        end
    end

    // Timer storage, one entry written per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
                r_count[i]   <= '0;
                r_preload[i] <= '0;
            end
            r_flag <= '0;
            r_mode <= '0;
        end else begin
            if (wr_count_en) begin
                r_count[addr] <= wr_count;
            end
            if (wr_preload_en) begin
                r_preload[addr] <= r_period;
            end
            if (wr_flag_en) begin
                r_flag[addr] <= wr_flag;
            end
            if (wr_mode_en) begin
                r_mode[addr] <= wr_mode;
            end
        end
    end

    // Output register: load when free or drained, drop valid on hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= M_DATA_BITS'({r_id_error, r_run_time, r_running, r_fired});
        end
    end

    // Checks
    `STB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_accept, !s_tready)
    `STB_ASSERT_NEXT(a_tick_walk, i_clk, i_rst_n, (r_state == ST_TICK) && !last_idx,
                     r_state == ST_TICK)
    `STB_ASSERT_IMPLY(a_err_no_check, i_clk, i_rst_n, m_tvalid && m_tdata[IDERR_POS],
                      !m_tdata[FIRED_POS] && !m_tdata[RUNNING_POS])

endmodule
